/* hdl/armt_pkg.sv */
// Package for the authorization rendezvous match table.
// Holds status codes, request kinds and slot defaults; no dependencies.
package armt_pkg;

  localparam int AUTH_SLOTS_DEF    = 16;
  localparam int WAITING_SLOTS_DEF = 16;

  localparam logic [1:0] KIND_AUTH   = 2'd0;
  localparam logic [1:0] KIND_CLIENT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  localparam logic [2:0] ST_MATCHED   = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_TICK      = 3'd5;

  localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

endpackage

/* hdl/armt_table.sv */
// One slot table: a memory of entries with a registered read port and a
// fill count. Depends on nothing; used twice by the top level.
module armt_table #(
  parameter int SLOTS = 16,
  parameter int DW    = 104
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [$clog2(SLOTS+1)-1:0] wr_addr,
  input  logic [DW-1:0]             wr_data,
  input  logic [$clog2(SLOTS+1)-1:0] rd_addr,
  output logic [DW-1:0]             rd_data,
  input  logic                      cnt_inc,
  input  logic                      cnt_dec,
  output logic [$clog2(SLOTS+1)-1:0] count
);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS+1);

  logic [DW-1:0] mem [SLOTS];

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr[AW-1:0]];
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cnt_inc) begin
      count <= count + CW'(1);
    end else if (cnt_dec) begin
      count <= count - CW'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk) disable iff (rst) !(cnt_inc && cnt_dec))
    else $error("count moved both ways");
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt_inc |-> (count < CW'(SLOTS))) else $error("table overfilled");
  a_no_under: assert property (@(posedge clk) disable iff (rst)
    cnt_dec |-> (count != '0)) else $error("table underflow");
`endif

endmodule

/* hdl/auth_rendezvous_match_table.sv */
// Top level of the authorization rendezvous match table.
// Depends on armt_pkg and armt_table.
//
// Usage: a request is taken when start is high and busy is low. kind
// selects an authorization arrival, a client arrival, a client removal or
// an expiry tick. The single result appears for one cycle with done high;
// the receiver cannot stall it. auth_timeout is written through cfg_valid
// and cfg_ready; cfg_ready is always high and the block only expects
// writes while idle.
// Sequence: the sequencer reads one slot of the searched table per step
// through the table's single registered read port, in a READ and a CHECK
// state a slot. A request that finds nothing gives its result when the
// scan passes the fill count, and busy falls in that cycle. A match or
// a removal first moves the last entry into the hit slot through the
// LREAD and LWAIT states, gives its result, and holds busy through the
// DONE state. A tick examines each authorization once and passes through
// LREAD and LWAIT for each expired entry.
// Throughput is one request per completion; busy is high meanwhile.
// Reset clears both fill counts and sets the timeout to 30000; entry
// contents are not cleared since only slots below a count are read.
module auth_rendezvous_match_table #(
  parameter int AUTH_SLOTS    = armt_pkg::AUTH_SLOTS_DEF,
  parameter int WAITING_SLOTS = armt_pkg::WAITING_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] account_id,
  input  logic [63:0] session_key,
  input  logic [7:0]  client_id,
  input  logic [31:0] now_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  matched_client,
  output logic [31:0] matched_account,
  output logic [63:0] matched_key,
  output logic [4:0]  expired_count
);
  localparam int ACW = $clog2(AUTH_SLOTS+1);
  localparam int WCW = $clog2(WAITING_SLOTS+1);
  localparam int ADW = 128;
  localparam int WDW = 104;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_LREAD = 3'd3;
  localparam logic [2:0] S_LWAIT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]  state;
  logic [31:0] auth_timeout;
  logic [1:0]  r_kind;
  logic [31:0] r_acct;
  logic [63:0] r_key;
  logic [7:0]  r_cid;
  logic [31:0] r_now;
  logic [8:0]  idx;
  logic [8:0]  hit_idx;
  logic [4:0]  expired;
  logic [7:0]  hit_handle;
  logic        on_auth;
  logic [8:0]  cur_cnt;
  logic        hit;
  logic [31:0] age;
  logic [8:0]  last;

  logic             a_wr, a_inc, a_dec;
  logic [ACW-1:0]   a_waddr, a_raddr, a_count;
  logic [ADW-1:0]   a_wdata, a_rdata;
  logic             w_wr, w_inc, w_dec;
  logic [WCW-1:0]   w_waddr, w_raddr, w_count;
  logic [WDW-1:0]   w_wdata, w_rdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      auth_timeout <= armt_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      auth_timeout <= cfg_data;
    end
  end

  armt_table #(.SLOTS(AUTH_SLOTS), .DW(ADW)) u_auth (
    .clk, .rst, .wr_en(a_wr), .wr_addr(a_waddr), .wr_data(a_wdata),
    .rd_addr(a_raddr), .rd_data(a_rdata), .cnt_inc(a_inc), .cnt_dec(a_dec),
    .count(a_count)
  );
  armt_table #(.SLOTS(WAITING_SLOTS), .DW(WDW)) u_wait (
    .clk, .rst, .wr_en(w_wr), .wr_addr(w_waddr), .wr_data(w_wdata),
    .rd_addr(w_raddr), .rd_data(w_rdata), .cnt_inc(w_inc), .cnt_dec(w_dec),
    .count(w_count)
  );

  // Ticks and client arrivals scan the authorization table.
  assign on_auth = (r_kind == armt_pkg::KIND_CLIENT) || (r_kind == armt_pkg::KIND_TICK);

  assign cur_cnt = on_auth ? 9'(a_count) : 9'(w_count);

  // Compare of the slot just read: a separate comparison for each request kind.
  assign age = r_now - a_rdata[31:0];
  always_comb begin
    unique case (r_kind)
      armt_pkg::KIND_AUTH:   hit = (w_rdata[103:72] == r_acct) && (w_rdata[71:8] == r_key);
      armt_pkg::KIND_CLIENT: hit = (a_rdata[127:96] == r_acct) && (a_rdata[95:32] == r_key);
      armt_pkg::KIND_REMOVE: hit = (w_rdata[7:0] == r_cid);
      default:               hit = (age >= auth_timeout);
    endcase
  end

  assign last = cur_cnt - 9'd1;

  // Memory port control.
  always_comb begin
    a_raddr = ACW'(idx);
    w_raddr = WCW'(idx);
    if (state == S_LREAD) begin
      a_raddr = ACW'(last);
      w_raddr = WCW'(last);
    end
    a_wr = 1'b0; a_inc = 1'b0; a_dec = 1'b0;
    w_wr = 1'b0; w_inc = 1'b0; w_dec = 1'b0;
    a_waddr = ACW'(hit_idx);
    w_waddr = WCW'(hit_idx);
    a_wdata = a_rdata;
    w_wdata = w_rdata;
    if (state == S_LWAIT) begin
      if (on_auth) begin a_wr = 1'b1; a_dec = 1'b1; end
      else begin w_wr = 1'b1; w_dec = 1'b1; end
    end else if (state == S_READ && idx >= cur_cnt &&
                 (r_kind == armt_pkg::KIND_AUTH || r_kind == armt_pkg::KIND_CLIENT)) begin
      // Append when the scan found nothing and there is room.
      if (r_kind == armt_pkg::KIND_AUTH && a_count < ACW'(AUTH_SLOTS)) begin
        a_wr = 1'b1; a_inc = 1'b1; a_waddr = a_count;
        a_wdata = {r_acct, r_key, r_now};
      end else if (r_kind == armt_pkg::KIND_CLIENT && w_count < WCW'(WAITING_SLOTS)) begin
        w_wr = 1'b1; w_inc = 1'b1; w_waddr = w_count;
        w_wdata = {r_acct, r_key, r_cid};
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          r_kind <= kind; r_acct <= account_id; r_key <= session_key;
          r_cid <= client_id; r_now <= now_ms;
          idx <= '0; expired <= '0;
          state <= S_READ;
        end
        S_READ: begin
          if (idx >= cur_cnt) begin
            done <= 1'b1;
            state <= S_IDLE;
            matched_client <= '0; matched_account <= '0; matched_key <= '0;
            expired_count <= '0;
            unique case (r_kind)
              armt_pkg::KIND_AUTH:
                status <= (a_count < ACW'(AUTH_SLOTS)) ? armt_pkg::ST_QUEUED : armt_pkg::ST_FULL;
              armt_pkg::KIND_CLIENT:
                status <= (w_count < WCW'(WAITING_SLOTS)) ? armt_pkg::ST_QUEUED : armt_pkg::ST_FULL;
              armt_pkg::KIND_REMOVE: status <= armt_pkg::ST_NOT_FOUND;
              default: begin
                status <= armt_pkg::ST_TICK;
                expired_count <= expired;
              end
            endcase
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (hit) begin
            hit_idx <= idx;
            hit_handle <= w_rdata[7:0];
            state <= S_LREAD;
          end else begin
            idx <= idx + 9'd1;
            state <= S_READ;
          end
        end
        S_LREAD: state <= S_LWAIT;
        S_LWAIT: begin
          // Last entry now written into the hit slot.
          if (r_kind == armt_pkg::KIND_TICK) begin
            if (expired != 5'd31) expired <= expired + 5'd1;
            state <= S_READ;
          end else begin
            done <= 1'b1;
            state <= S_DONE;
            matched_client <= '0; matched_account <= '0; matched_key <= '0;
            expired_count <= '0;
            if (r_kind == armt_pkg::KIND_REMOVE) begin
              status <= armt_pkg::ST_REMOVED;
            end else begin
              status <= armt_pkg::ST_MATCHED;
              matched_client <= (r_kind == armt_pkg::KIND_AUTH) ? hit_handle : r_cid;
              matched_account <= r_acct;
              matched_key <= r_key;
            end
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without request");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
`endif

endmodule

/* dv/tb.sv */
// Testbench for the authorization rendezvous match table.
// Depends on armt_pkg and auth_rendezvous_match_table; self-checking, no files read.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] acct;
    logic [63:0] key;
    logic [7:0]  cid;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  client;
    logic [31:0] acct;
    logic [63:0] key;
    logic [4:0]  expired;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = '0;
  logic [31:0] account_id = '0;
  logic [63:0] session_key = '0;
  logic [7:0] client_id = '0;
  logic [31:0] now_ms = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic done;
  logic [2:0] status;
  logic [7:0] matched_client;
  logic [31:0] matched_account;
  logic [63:0] matched_key;
  logic [4:0] expired_count;

  auth_rendezvous_match_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .account_id(account_id), .session_key(session_key), .client_id(client_id),
    .now_ms(now_ms), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .done(done), .status(status),
    .matched_client(matched_client), .matched_account(matched_account),
    .matched_key(matched_key), .expired_count(expired_count)
  );

  always #5 clk = ~clk;

  // Shadow copy of both tables and the timeout.
  logic [31:0] timeout_ms;
  logic [31:0] auth_acct_q[NSLOT];
  logic [63:0] auth_key_q[NSLOT];
  logic [31:0] auth_time_q[NSLOT];
  int auth_fill;
  logic [7:0] wait_handle_q[NSLOT];
  logic [31:0] wait_acct_q[NSLOT];
  logic [63:0] wait_key_q[NSLOT];
  int wait_fill;

  outcome_t pending_outcomes[$];
  int mismatches = 0;
  int cycles = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int timeout_writes = 0;

  // Pools of identities so that matches and duplicates occur often.
  logic [31:0] acct_pool[8];
  logic [63:0] key_pool[8];
  logic [31:0] clock_ms;

  function automatic void drop_auth(int i);
    auth_acct_q[i] = auth_acct_q[auth_fill-1];
    auth_key_q[i]  = auth_key_q[auth_fill-1];
    auth_time_q[i] = auth_time_q[auth_fill-1];
    auth_fill--;
  endfunction

  function automatic void drop_waiting(int i);
    wait_handle_q[i] = wait_handle_q[wait_fill-1];
    wait_acct_q[i]   = wait_acct_q[wait_fill-1];
    wait_key_q[i]    = wait_key_q[wait_fill-1];
    wait_fill--;
  endfunction

  // Applies one request to the shadow tables and returns its outcome.
  function automatic outcome_t pair_request(request_t r);
    outcome_t o;
    bit hit;
    int i;
    o = '0;
    hit = 0;
    case (r.kind)
      armt_pkg::KIND_AUTH: begin
        o.status = armt_pkg::ST_QUEUED;
        for (i = 0; i < wait_fill && !hit; i++) begin
          if (wait_acct_q[i] == r.acct && wait_key_q[i] == r.key) begin
            hit = 1;
            o.status = armt_pkg::ST_MATCHED;
            o.client = wait_handle_q[i];
            o.acct = r.acct;
            o.key = r.key;
            drop_waiting(i);
          end
        end
        if (!hit) begin
          if (auth_fill < NSLOT) begin
            auth_acct_q[auth_fill] = r.acct;
            auth_key_q[auth_fill] = r.key;
            auth_time_q[auth_fill] = r.now;
            auth_fill++;
          end else begin
            o.status = armt_pkg::ST_FULL;
          end
        end
      end
      armt_pkg::KIND_CLIENT: begin
        o.status = armt_pkg::ST_QUEUED;
        for (i = 0; i < auth_fill && !hit; i++) begin
          if (auth_acct_q[i] == r.acct && auth_key_q[i] == r.key) begin
            hit = 1;
            o.status = armt_pkg::ST_MATCHED;
            o.client = r.cid;
            o.acct = r.acct;
            o.key = r.key;
            drop_auth(i);
          end
        end
        if (!hit) begin
          if (wait_fill < NSLOT) begin
            wait_handle_q[wait_fill] = r.cid;
            wait_acct_q[wait_fill] = r.acct;
            wait_key_q[wait_fill] = r.key;
            wait_fill++;
          end else begin
            o.status = armt_pkg::ST_FULL;
          end
        end
      end
      armt_pkg::KIND_REMOVE: begin
        o.status = armt_pkg::ST_NOT_FOUND;
        for (i = 0; i < wait_fill && !hit; i++) begin
          if (wait_handle_q[i] == r.cid) begin
            hit = 1;
            o.status = armt_pkg::ST_REMOVED;
            drop_waiting(i);
          end
        end
      end
      default: begin
        o.status = armt_pkg::ST_TICK;
        i = 0;
        while (i < auth_fill) begin
          if (32'(r.now - auth_time_q[i]) >= timeout_ms) begin
            drop_auth(i);
            if (o.expired != 5'd31) o.expired++;
          end else begin
            i++;
          end
        end
      end
    endcase
    return o;
  endfunction

  // Result monitor: every strobe must meet the oldest expectation.
  always @(posedge clk) begin
    outcome_t got, want;
    cycles <= cycles + 1;
    if (!rst && done) begin
      got = '{status, matched_client, matched_account, matched_key, expired_count};
      results_seen <= results_seen + 1;
      if (pending_outcomes.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %p", got);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          if (mismatches < 10) $display("mismatch: expected %p, got %p", want, got);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Holds start until the request is taken, then drops it.
  task automatic send_request(request_t r, bit with_gap);
    int gap;
    gap = with_gap ? $urandom_range(0, 12) : 0;
    repeat (gap) @(posedge clk);
    kind <= r.kind;
    account_id <= r.acct;
    session_key <= r.key;
    client_id <= r.cid;
    now_ms <= r.now;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(pair_request(r));
    requests_sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one request whose status is written out by hand, then checks the prediction against it.
  task automatic send_known(request_t r, logic [2:0] st, logic [4:0] expd);
    outcome_t o;
    send_request(r, 0);
    o = pending_outcomes[pending_outcomes.size()-1];
    if (o.status !== st || (st == armt_pkg::ST_TICK && o.expired !== expd)) begin
      $display("directed row disagrees with predictor: %p", o);
      mismatches++;
    end
  endtask

  task automatic drain;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_ms = v;
    timeout_writes++;
  endtask

  function automatic request_t random_request();
    request_t r;
    int p;
    r.now = clock_ms;
    p = $urandom_range(0, 99);
    r.kind = (p < 38) ? armt_pkg::KIND_AUTH : (p < 76) ? armt_pkg::KIND_CLIENT :
             (p < 90) ? armt_pkg::KIND_REMOVE : armt_pkg::KIND_TICK;
    if ($urandom_range(0, 9) == 0) begin
      r.acct = $urandom;
      r.key = {$urandom, $urandom};
    end else begin
      r.acct = acct_pool[$urandom_range(0, 7)];
      r.key = key_pool[$urandom_range(0, 7)];
    end
    r.cid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
    return r;
  endfunction

  typedef struct {
    request_t   r;
    bit         known;
    logic [2:0] st;
    logic [4:0] expd;
  } row_t;

  initial begin
    row_t rows[$];
    request_t r;
    logic [31:0] settings[6];
    int n, phase, i;

    timeout_ms = armt_pkg::TIMEOUT_RESET;
    auth_fill = 0;
    wait_fill = 0;
    clock_ms = 32'hFFFF_F000;
    for (i = 0; i < 8; i++) begin
      acct_pool[i] = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'd0 : $urandom;
      key_pool[i] = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (i == 1) ? 64'd0
                             : {$urandom, $urandom};
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: empty tables, extremes, duplicates, full table, wrap.
    rows.push_back('{'{armt_pkg::KIND_TICK, 0, 0, 0, 32'd0}, 1, armt_pkg::ST_TICK, 5'd0});
    rows.push_back('{'{armt_pkg::KIND_REMOVE, 0, 0, 8'hFF, 0}, 1,
                     armt_pkg::ST_NOT_FOUND, 0});
    rows.push_back('{'{armt_pkg::KIND_AUTH, '1, '1, 8'hFF, '1}, 1, armt_pkg::ST_QUEUED, 0});
    rows.push_back('{'{armt_pkg::KIND_AUTH, '1, '1, 8'h00, '1}, 1, armt_pkg::ST_QUEUED, 0});
    rows.push_back('{'{armt_pkg::KIND_CLIENT, '1, '1, 8'hFF, 0}, 1,
                     armt_pkg::ST_MATCHED, 0});
    rows.push_back('{'{armt_pkg::KIND_CLIENT, 0, 0, 8'h00, 0}, 1, armt_pkg::ST_QUEUED, 0});
    rows.push_back('{'{armt_pkg::KIND_CLIENT, 0, 0, 8'h5A, 0}, 1, armt_pkg::ST_QUEUED, 0});
    rows.push_back('{'{armt_pkg::KIND_AUTH, 0, 0, 8'hA5, 32'd5}, 1,
                     armt_pkg::ST_MATCHED, 0});
    rows.push_back('{'{armt_pkg::KIND_REMOVE, '1, '1, 8'h5A, 0}, 1,
                     armt_pkg::ST_REMOVED, 0});
    rows.push_back('{'{armt_pkg::KIND_REMOVE, 0, 0, 8'h5A, 0}, 1,
                     armt_pkg::ST_NOT_FOUND, 0});
    // Elapsed time wraps past zero: 30000 after 0xFFFFFFFF is 29999.
    rows.push_back('{'{armt_pkg::KIND_TICK, 0, 0, 0, 32'd29999}, 1,
                     armt_pkg::ST_TICK, 5'd1});
    rows.push_back('{'{armt_pkg::KIND_TICK, 0, 0, 0, 32'd30000}, 0, 0, 0});
    rows.push_back('{'{armt_pkg::KIND_TICK, '1, '1, '1, 32'd30000}, 1,
                     armt_pkg::ST_TICK, 5'd0});
    // Fill the authorization table and overflow it.
    for (i = 0; i < 17; i++)
      rows.push_back('{'{armt_pkg::KIND_AUTH, 32'(i), 64'(i) << 40, 8'(i), 32'd100},
                       (i == 16), armt_pkg::ST_FULL, 0});
    rows.push_back('{'{armt_pkg::KIND_TICK, 0, 0, 0, 32'd30100}, 1,
                     armt_pkg::ST_TICK, 5'd16});
    foreach (rows[k]) begin
      if (rows[k].known) send_known(rows[k].r, rows[k].st, rows[k].expd);
      else send_request(rows[k].r, 1);
    end
    // Fill the waiting table and overflow it.
    for (i = 0; i < 17; i++) begin
      r = '{armt_pkg::KIND_CLIENT, 32'd7, 64'd9, 8'(i), 32'd0};
      if (i == 16) send_known(r, armt_pkg::ST_FULL, 0);
      else send_request(r, 0);
    end
    drain();

    // Random phases, each under its own timeout setting.
    settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd500, 32'd4000, armt_pkg::TIMEOUT_RESET};
    for (phase = 0; phase < 6; phase++) begin
      write_timeout(settings[phase]);
      n = 310;
      for (i = 0; i < n; i++) begin
        clock_ms += $urandom_range(0, 40) == 0 ? $urandom : $urandom_range(0, 300);
        // Stretches of back-to-back requests alternate with gapped ones.
        send_request(random_request(), ((i / 40) % 2) == 0);
      end
      drain();
    end

    $display("%0d requests sent, %0d results checked, %0d timeout writes",
             requests_sent, results_seen, timeout_writes);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
